### rtl/fixed_column_pose_record_parser_assert.svh
// Assertion macros for the fixed-column pose record parser.
// Included by RTL files that carry assertions; no other dependencies.
`ifndef FIXED_COLUMN_POSE_RECORD_PARSER_ASSERT_SVH
`define FIXED_COLUMN_POSE_RECORD_PARSER_ASSERT_SVH

// Plain property, checked on every clock edge outside reset
`define FCP_ASSERT(lbl, clk_s, rst_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
        else $error("fcp assertion failed");

// Same-cycle implication
`define FCP_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("fcp implication failed");

// Next-cycle implication
`define FCP_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("fcp next-cycle implication failed");

`endif

### rtl/fcp_pkg.sv
// Shared constants, types and digit weight table for the pose record parser.
// No dependencies.
package fcp_pkg;

    localparam int NUM_FIELDS = 6;

    localparam logic [7:0] DOT_CHAR   = 8'h2e;
    localparam logic [7:0] MINUS_CHAR = 8'h2d;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] ONE_CHAR   = 8'h31;
    localparam logic [7:0] ZERO_CHAR  = 8'h30;

    localparam logic [5:0] IDLE_OFFSET   = 6'd63;
    localparam logic [5:0] SENSOR_OFFSET = 6'd1;
    localparam logic [5:0] FIELD0_OFFSET = 6'd4;

    typedef logic [3:0]         pos_t;
    typedef logic [2:0]         field_t;
    typedef logic signed [25:0] value_t;

    // Positions within a nine-byte field
    localparam pos_t POS_SIGN = 4'd0;
    localparam pos_t POS_D5   = 4'd1;
    localparam pos_t POS_D4   = 4'd2;
    localparam pos_t POS_D3   = 4'd3;
    localparam pos_t POS_DOT  = 4'd4;
    localparam pos_t POS_D2   = 4'd5;
    localparam pos_t POS_D1   = 4'd6;
    localparam pos_t POS_D0   = 4'd7;
    localparam pos_t POS_LAST = 4'd8;

    typedef struct packed {
        logic       vld;
        logic [7:0] sensor_index;
        field_t     field_number;
        value_t     value;
    } result_t;

    function automatic logic [16:0] digit_weight(input pos_t pos);
        logic [16:0] w;
        begin
            case (pos)
                POS_D5:  w = 17'd100000;
                POS_D4:  w = 17'd10000;
                POS_D3:  w = 17'd1000;
                POS_D2:  w = 17'd100;
                POS_D1:  w = 17'd10;
                POS_D0:  w = 17'd1;
                default: w = 17'd0;
            endcase
            return w;
        end
    endfunction

endpackage

### rtl/fcp_parse.sv
// Record parser core: column tracking, sign/dot flags and digit accumulation.
// Depends on fcp_pkg.
module fcp_parse
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    input  logic              line_start,
    output fcp_pkg::result_t  res
);

    logic [5:0]            off_reg, off_next;
    fcp_pkg::field_t       fld_reg, fld_next;
    fcp_pkg::pos_t         pos_reg, pos_next;
    logic [7:0]            sensor_reg, sensor_next;
    logic                  neg_reg, neg_next;
    logic                  dot_reg, dot_next;
    fcp_pkg::value_t       part_reg, part_next;

    logic                  run;
    logic                  act;
    logic                  is_minus, is_space, is_dot;
    logic signed [8:0]     digit;
    logic signed [26:0]    prod;
    fcp_pkg::value_t       contrib;
    fcp_pkg::value_t       sum;

    assign run      = line_start || (off_reg != fcp_pkg::IDLE_OFFSET);
    assign is_minus = (rx_byte == fcp_pkg::MINUS_CHAR);
    assign is_space = (rx_byte == fcp_pkg::SPACE_CHAR);
    assign is_dot   = (rx_byte == fcp_pkg::DOT_CHAR);

    // column and field position of the byte now arriving
    always_comb
    begin
        off_next = line_start ? 6'd0 : off_reg + 6'd1;
        fld_next = fld_reg;
        pos_next = pos_reg;
        if (off_next == fcp_pkg::FIELD0_OFFSET)
        begin
            fld_next = '0;
            pos_next = fcp_pkg::POS_SIGN;
        end
        else if (!line_start && off_reg >= fcp_pkg::FIELD0_OFFSET)
        begin
            if (pos_reg == fcp_pkg::POS_LAST)
            begin
                pos_next = fcp_pkg::POS_SIGN;
                fld_next = fld_reg + 3'd1;
            end
            else
            begin
                pos_next = pos_reg + 4'd1;
            end
        end
    end

    assign act = run && (off_next >= fcp_pkg::FIELD0_OFFSET)
                 && (fld_next < 3'(fcp_pkg::NUM_FIELDS));

    assign digit   = $signed({1'b0, rx_byte}) - $signed({1'b0, fcp_pkg::ZERO_CHAR});
    assign prod    = 27'(digit) * $signed({10'd0, fcp_pkg::digit_weight(pos_next)});
    assign contrib = is_space ? '0 : prod[25:0];
    assign sum     = part_reg + contrib;

    always_comb
    begin
        sensor_next = sensor_reg;
        neg_next    = neg_reg;
        dot_next    = dot_reg;
        part_next   = part_reg;
        res         = '0;
        res.sensor_index = sensor_reg;
        res.field_number = fld_next;
        res.value        = neg_reg ? -sum : sum;
        if (run && off_next == fcp_pkg::SENSOR_OFFSET)
        begin
            sensor_next = rx_byte - fcp_pkg::ONE_CHAR;
        end
        if (act)
        begin
            case (pos_next)
                fcp_pkg::POS_SIGN:
                begin
                    part_next = '0;
                    dot_next  = 1'b0;
                    neg_next  = is_minus;
                end
                fcp_pkg::POS_D5, fcp_pkg::POS_D4, fcp_pkg::POS_D3:
                begin
                    if (is_minus)
                        neg_next = 1'b1;
                    else
                        part_next = sum;
                end
                fcp_pkg::POS_DOT:
                begin
                    dot_next = is_dot;
                end
                fcp_pkg::POS_D2, fcp_pkg::POS_D1:
                begin
                    part_next = sum;
                end
                fcp_pkg::POS_D0:
                begin
                    part_next = sum;
                    res.vld   = dot_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg    <= fcp_pkg::IDLE_OFFSET;
            fld_reg    <= '0;
            pos_reg    <= '0;
            sensor_reg <= '0;
            neg_reg    <= 1'b0;
            dot_reg    <= 1'b0;
            part_reg   <= '0;
        end
        else if (step && run)
        begin
            off_reg    <= off_next;
            fld_reg    <= fld_next;
            pos_reg    <= pos_next;
            sensor_reg <= sensor_next;
            neg_reg    <= neg_next;
            dot_reg    <= dot_next;
            part_reg   <= part_next;
        end
    end

endmodule

### rtl/fixed_column_pose_record_parser.sv
// A byte goes to the input register; the result of a finished field goes to the
// result register and on m_tdata. Throughput: one byte per cycle while no result
// waits on m_tready; an empty input register takes a byte while a result waits.
// Reset (rst_n, async, active low): both stages empty, parser idle until the
// next byte marked by s_tuser as a line start.
// Top level of the pose record parser; depends on fcp_pkg and fcp_parse.
module fixed_column_pose_record_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] line_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] sensor_index, [33:8] value, [39:34] zero
    output logic [2:0]  m_tuser    // [2:0] field_number
);

`include "fixed_column_pose_record_parser_assert.svh"

    logic              in_vld_reg, in_vld_next;
    logic [7:0]        in_byte_reg;
    logic              in_ls_reg;
    logic              out_vld_reg, out_vld_next;
    fcp_pkg::result_t  out_reg;
    fcp_pkg::result_t  res;
    logic              can_parse;
    logic              step;
    logic              s_xfer;

    assign can_parse = !out_vld_reg || m_tready;
    assign step      = in_vld_reg && can_parse;
    assign s_tready  = !in_vld_reg || can_parse;
    assign s_xfer    = s_tvalid && s_tready;

    fcp_parse u_parse
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .rx_byte    (in_byte_reg),
        .line_start (in_ls_reg),
        .res        (res)
    );

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (s_xfer)
            in_vld_next = 1'b1;
        else if (step)
            in_vld_next = 1'b0;
        out_vld_next = out_vld_reg;
        if (can_parse)
            out_vld_next = step && res.vld;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            in_byte_reg <= s_tdata;
            in_ls_reg   <= s_tuser;
        end
        if (step && res.vld)
            out_reg <= res;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, out_reg.value, out_reg.sensor_index};
    assign m_tuser  = out_reg.field_number;

    `FCP_ASSERT_IMP(a_empty_ready, clk, rst_n, !in_vld_reg, s_tready)
    `FCP_ASSERT_IMP(a_field_range, clk, rst_n, m_tvalid,
                    m_tuser < 3'(fcp_pkg::NUM_FIELDS))
    `FCP_ASSERT_NXT(a_in_hold, clk, rst_n, in_vld_reg && !can_parse, in_vld_reg)
    `FCP_ASSERT(a_out_from_step, clk, rst_n, !$rose(m_tvalid) || $past(step))

endmodule
